>>> sv/ftr_pkg.sv
// Shared types and constants for the fat tree port router.
package ftr_pkg;

  localparam int DEST_W = 16;
  localparam int PORT_W = 7;
  localparam int HR_W = 7;
  localparam int LVL_W = 3;
  localparam int LEV_W = 4;
  localparam int IDX_W = 16;
  localparam int OUT_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 2;

  // Divisor width: powers of the half radix saturate at 2**DEST_W.
  localparam int DIV_W = DEST_W + 1;
  localparam int RECIP_SHIFT = 2 * DEST_W;
  localparam int RECIP_W = RECIP_SHIFT + 1;

  localparam logic [LEV_W-1:0] MAX_LEVELS = LEV_W'(8);
  localparam logic [DIV_W-1:0] POW_SAT = {1'b1, {DEST_W{1'b0}}};
  localparam logic [RECIP_W-1:0] RECIP_ONE = {1'b1, {RECIP_SHIFT{1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_DOWN_PORTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TREE_LEVELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUTER_LEVEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROUTER_INDEX = 2'd3;

  localparam logic [1:0] JOB_M1 = 2'd0;
  localparam logic [1:0] JOB_M2 = 2'd1;
  localparam logic [1:0] JOB_MH = 2'd2;
  localparam logic [1:0] JOB_GRP = 2'd3;

  typedef enum logic [1:0] {
    ST_POW,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DONE
  } ftr_setup_state_t;

  typedef struct packed {
    logic busy;
    logic top;
    logic [HR_W-1:0] hr;
    logic [DIV_W-1:0] d1;
    logic [DIV_W-1:0] d2;
    logic [RECIP_W-1:0] m1;
    logic [RECIP_W-1:0] m2;
    logic [RECIP_W-1:0] mh;
    logic [DEST_W-1:0] grp_r;
  } ftr_route_cfg_t;

endpackage

>>> sv/fat_tree_port_router.sv
// Top level of the fat tree port router.
//
//   channel   direction  handshake              word
//   in        input      in_valid / in_ready    dest_endpoint, arrival_port
//   out       output     out_valid / out_ready  egress_port
//   cfg       input      cfg_we                 cfg_index, cfg_data
//
// One word is accepted per cycle while in_ready is high; it passes five register
// stages, and its result leaves the last of them on egress_port.
// After reset and after every configuration write a setup pass computes the
// divisors and reciprocals with one serial divider; it first forms the powers of
// the half radix and then runs four divisions, and in_ready stays low meanwhile.
// Reset is synchronous and clears all valid bits.
// A stalled output holds its word; each stage moves on only when the next has room.
module fat_tree_port_router import ftr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DEST_W-1:0]     dest_endpoint,
  input  logic [PORT_W-1:0]     arrival_port,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_W-1:0]      egress_port,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ftr_route_cfg_t route_cfg;

  ftr_setup u_setup (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .route_cfg(route_cfg)
  );

  ftr_pipe u_pipe (
    .clk(clk),
    .rst(rst),
    .route_cfg(route_cfg),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .dest_endpoint(dest_endpoint),
    .arrival_port(arrival_port),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .egress_port(egress_port)
  );

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("input accepted during setup pass");

  a_ready_low_cause: assert property (@(posedge clk) disable iff (rst)
    (!in_ready && !route_cfg.busy) |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

endmodule

>>> sv/ftr_div.sv
// Bit-serial restoring divider used for the setup pass.
module ftr_div import ftr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [RECIP_W-1:0] dividend,
  input  logic [DIV_W-1:0]   divisor,
  output logic               done,
  output logic [RECIP_W-1:0] quotient
);

  localparam int CNT_W = $clog2(RECIP_W);

  logic [DIV_W-1:0] rem;
  logic [RECIP_W-1:0] dvd;
  logic [DIV_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic running;
  logic [DIV_W:0] rem_sh;
  logic qbit;
  logic [DIV_W-1:0] rem_next;

  always_comb begin
    rem_sh = {rem, dvd[RECIP_W-1]};
    qbit = rem_sh >= {1'b0, dsr};
    rem_next = qbit ? DIV_W'(rem_sh - {1'b0, dsr}) : rem_sh[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        dvd <= dividend;
        dsr <= divisor;
        cnt <= '0;
        running <= 1'b1;
      end else if (running) begin
        rem <= rem_next;
        dvd <= {dvd[RECIP_W-2:0], qbit};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(RECIP_W - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd;

endmodule

>>> sv/ftr_setup.sv
// Configuration registers and the setup sequencer for divisors and reciprocals.
module ftr_setup import ftr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output ftr_route_cfg_t        route_cfg
);

  logic [HR_W-1:0] down_ports;
  logic [LEV_W-1:0] tree_levels;
  logic [LVL_W-1:0] router_level;
  logic [IDX_W-1:0] router_index;

  ftr_setup_state_t state, state_next;

  logic [HR_W-1:0] hr;
  logic [LEV_W-1:0] levels;
  logic [LEV_W-1:0] lvl_plus;
  logic top;

  logic [DIV_W-1:0] p;
  logic [DIV_W+HR_W-1:0] pprod;
  logic [DIV_W-1:0] p_sat;
  logic [LEV_W-1:0] k;
  logic [1:0] job;

  logic [DIV_W-1:0] d1;
  logic [DIV_W-1:0] d2;
  logic [RECIP_W-1:0] m1;
  logic [RECIP_W-1:0] m2;
  logic [RECIP_W-1:0] mh;
  logic [DEST_W-1:0] grp_r;

  logic div_start;
  logic div_done;
  logic busy;
  logic [RECIP_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic [RECIP_W-1:0] div_quotient;

  always_comb begin
    hr = (down_ports == '0) ? HR_W'(1) : down_ports;
    levels = (tree_levels > MAX_LEVELS) ? MAX_LEVELS : tree_levels;
    lvl_plus = {1'b0, router_level} + LEV_W'(1);
    top = (levels != '0) && (lvl_plus == levels);
    pprod = p * hr;
    p_sat = (pprod > (DIV_W + HR_W)'(POW_SAT)) ? POW_SAT : pprod[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_ports <= HR_W'(2);
      tree_levels <= LEV_W'(1);
      router_level <= '0;
      router_index <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DOWN_PORTS: down_ports <= cfg_data[HR_W-1:0];
        REG_TREE_LEVELS: tree_levels <= cfg_data[LEV_W-1:0];
        REG_ROUTER_LEVEL: router_level <= cfg_data[LVL_W-1:0];
        REG_ROUTER_INDEX: router_index <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_POW: begin
        if (k == lvl_plus) state_next = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: state_next = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (div_done) state_next = (job == JOB_GRP) ? ST_DONE : ST_DIV_LOAD;
      end
      ST_DONE: state_next = ST_DONE;
      default: state_next = ST_POW;
    endcase
    if (cfg_we) state_next = ST_POW;
  end

  always_comb begin
    div_start = (state == ST_DIV_LOAD);
    busy = (state != ST_DONE);
  end

  always_comb begin
    div_dividend = (job == JOB_GRP) ? RECIP_W'(router_index) : RECIP_ONE;
    case (job)
      JOB_M2: div_divisor = d2;
      JOB_MH: div_divisor = DIV_W'(hr);
      default: div_divisor = d1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_POW;
      k <= '0;
      p <= DIV_W'(1);
      job <= JOB_M1;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        k <= '0;
        p <= DIV_W'(1);
        job <= JOB_M1;
      end else if (state == ST_POW) begin
        if (k == {1'b0, router_level}) d1 <= p;
        if (k == lvl_plus) d2 <= p;
        else begin
          p <= p_sat;
          k <= k + LEV_W'(1);
        end
      end else if (state == ST_DIV_RUN && div_done) begin
        case (job)
          JOB_M1: m1 <= div_quotient;
          JOB_M2: m2 <= div_quotient;
          JOB_MH: mh <= div_quotient;
          default: grp_r <= div_quotient[DEST_W-1:0];
        endcase
        job <= job + 2'd1;
      end
    end
  end

  ftr_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(div_dividend),
    .divisor(div_divisor),
    .done(div_done),
    .quotient(div_quotient)
  );

  always_comb begin
    route_cfg.busy = busy;
    route_cfg.top = top;
    route_cfg.hr = hr;
    route_cfg.d1 = d1;
    route_cfg.d2 = d2;
    route_cfg.m1 = m1;
    route_cfg.m2 = m2;
    route_cfg.mh = mh;
    route_cfg.grp_r = grp_r;
  end

endmodule

>>> sv/ftr_pipe.sv
// Five-stage routing pipeline: reciprocal divides, corrections and port select.
module ftr_pipe import ftr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ftr_route_cfg_t    route_cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DEST_W-1:0] dest_endpoint,
  input  logic [PORT_W-1:0] arrival_port,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  egress_port
);

  localparam int PROD_W = DEST_W + RECIP_W;
  localparam int PPROD_W = PORT_W + RECIP_W;

  logic v1, v2, v3, v4, v5;
  logic adv1, adv2, adv3, adv4, adv5;

  logic [PROD_W-1:0] mul1, mul2;
  logic [PPROD_W-1:0] mulp;

  logic [DEST_W-1:0] s1_dest, s1_q1e, s1_q2e;
  logic [PORT_W-1:0] s1_port, s1_qpe;

  logic [DEST_W+DIV_W-1:0] pr1_full, pr2_full;
  logic [PORT_W+HR_W-1:0] prp_full;
  logic [DEST_W-1:0] s2_dest, s2_q1e, s2_q2e, s2_pr1, s2_pr2;
  logic [PORT_W-1:0] s2_port, s2_prp;

  logic [DEST_W-1:0] r1, r2;
  logic [PORT_W-1:0] rp;
  logic [DEST_W-1:0] s3_q1, s3_q2;
  logic [PORT_W-1:0] s3_pmod;

  logic [DEST_W+HR_W-1:0] mulh_full;
  logic [DEST_W-1:0] s4_q1, s4_mul;
  logic [PORT_W-1:0] s4_pmod;
  logic s4_mism;

  logic [OUT_W-1:0] res;
  logic [OUT_W-1:0] s5_res;

  always_comb begin
    adv5 = !v5 || out_ready;
    adv4 = !v4 || adv5;
    adv3 = !v3 || adv4;
    adv2 = !v2 || adv3;
    adv1 = !v1 || adv2;
    in_ready = adv1 && !route_cfg.busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid && !route_cfg.busy;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
    end
  end

  // The reciprocal estimate of each quotient is exact or one short.
  always_comb begin
    mul1 = dest_endpoint * route_cfg.m1;
    mul2 = dest_endpoint * route_cfg.m2;
    mulp = arrival_port * route_cfg.mh;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_dest <= dest_endpoint;
      s1_port <= arrival_port;
      s1_q1e <= mul1[RECIP_SHIFT +: DEST_W];
      s1_q2e <= mul2[RECIP_SHIFT +: DEST_W];
      s1_qpe <= mulp[RECIP_SHIFT +: PORT_W];
    end
  end

  always_comb begin
    pr1_full = s1_q1e * route_cfg.d1;
    pr2_full = s1_q2e * route_cfg.d2;
    prp_full = s1_qpe * route_cfg.hr;
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_dest <= s1_dest;
      s2_port <= s1_port;
      s2_q1e <= s1_q1e;
      s2_q2e <= s1_q2e;
      s2_pr1 <= pr1_full[DEST_W-1:0];
      s2_pr2 <= pr2_full[DEST_W-1:0];
      s2_prp <= prp_full[PORT_W-1:0];
    end
  end

  always_comb begin
    r1 = s2_dest - s2_pr1;
    r2 = s2_dest - s2_pr2;
    rp = s2_port - s2_prp;
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_q1 <= s2_q1e + DEST_W'({1'b0, r1} >= route_cfg.d1);
      s3_q2 <= s2_q2e + DEST_W'({1'b0, r2} >= route_cfg.d2);
      s3_pmod <= (rp >= route_cfg.hr) ? PORT_W'(rp - route_cfg.hr) : rp;
    end
  end

  assign mulh_full = s3_q2 * route_cfg.hr;

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_q1 <= s3_q1;
      s4_mul <= mulh_full[DEST_W-1:0];
      s4_pmod <= s3_pmod;
      s4_mism <= s3_q2 != route_cfg.grp_r;
    end
  end

  always_comb begin
    if (route_cfg.top) begin
      res = OUT_W'(s4_q1);
    end else if (s4_mism) begin
      res = OUT_W'(s4_pmod) + OUT_W'(route_cfg.hr);
    end else begin
      res = OUT_W'(s4_q1 - s4_mul);
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) s5_res <= res;
  end

  assign out_valid = v5;
  assign egress_port = s5_res;

endmodule
